// ----- design/bod_pkg.sv -----
package bod_pkg;

  // register indexes on the configuration port
  localparam logic [2:0] CFG_LOW_CLIP  = 3'd0;
  localparam logic [2:0] CFG_HIGH_CLIP = 3'd1;
  localparam logic [2:0] CFG_DELTA_FLR = 3'd2;
  localparam logic [2:0] CFG_DC_BUCKET = 3'd3;
  localparam logic [2:0] CFG_MIN_OVS   = 3'd4;

  localparam logic [6:0] BLOCK_LEN   = 7'd64;
  localparam logic [6:0] LAST_INDEX  = 7'd63;
  // smoothing window reaches one row (8 samples) ahead of the center
  localparam logic [6:0] WIN_LEAD    = 7'd8;
  localparam logic [6:0] WIN_DELAY   = 7'd9;
  localparam logic [6:0] SMOOTH_END  = 7'd72;

  typedef enum logic [1:0] {
    MARK_NONE   = 2'd0,
    MARK_DARK   = 2'd1,
    MARK_BRIGHT = 2'd2
  } bod_mark_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_MARK,
    ST_DECIDE,
    ST_FILL,
    ST_SMOOTH,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_WAIT
  } bod_state_t;

  typedef struct packed {
    logic       load;
    logic       mark;
    logic       decide;
    logic       fill;
    logic       smooth;
    logic       emit_rd;
    logic       emit_ld;
    logic       swap;
    logic [6:0] step;
  } bod_cmd_t;

  typedef struct packed {
    logic changed;
    logic out_valid;
  } bod_stat_t;

endpackage

// ----- design/bod_ctrl.sv -----
module bod_ctrl #(
  parameter int SMOOTH_PASSES = 3
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              out_stall,
  input  bod_pkg::bod_stat_t stat,
  output logic              in_stall,
  output bod_pkg::bod_cmd_t cmd
);

  localparam int PW = (SMOOTH_PASSES > 1) ? $clog2(SMOOTH_PASSES) : 1;

  bod_pkg::bod_state_t state, state_next;
  logic [6:0]          cnt, cnt_next;
  logic [PW-1:0]       pass, pass_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bod_pkg::ST_LOAD;
      cnt   <= '0;
      pass  <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      pass  <= pass_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    pass_next  = pass;
    in_stall   = 1'b1;
    cmd        = '0;
    cmd.step   = cnt;
    case (state)
      bod_pkg::ST_LOAD: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (cnt == bod_pkg::LAST_INDEX) begin
            state_next = bod_pkg::ST_MARK;
            cnt_next   = '0;
          end else begin
            cnt_next = cnt + 7'd1;
          end
        end
      end
      bod_pkg::ST_MARK: begin
        cmd.mark = 1'b1;
        if (cnt == bod_pkg::BLOCK_LEN) begin
          state_next = bod_pkg::ST_DECIDE;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 7'd1;
        end
      end
      bod_pkg::ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = bod_pkg::ST_FILL;
      end
      bod_pkg::ST_FILL: begin
        cmd.fill = 1'b1;
        if (cnt == bod_pkg::BLOCK_LEN) begin
          cnt_next   = '0;
          pass_next  = '0;
          state_next = stat.changed ? bod_pkg::ST_SMOOTH : bod_pkg::ST_EMIT_RD;
        end else begin
          cnt_next = cnt + 7'd1;
        end
      end
      bod_pkg::ST_SMOOTH: begin
        cmd.smooth = 1'b1;
        if (cnt == bod_pkg::SMOOTH_END) begin
          cmd.swap = 1'b1;
          cnt_next = '0;
          if (pass == PW'(SMOOTH_PASSES - 1)) begin
            state_next = bod_pkg::ST_EMIT_RD;
          end else begin
            pass_next = pass + PW'(1);
          end
        end else begin
          cnt_next = cnt + 7'd1;
        end
      end
      bod_pkg::ST_EMIT_RD: begin
        cmd.emit_rd = 1'b1;
        state_next  = bod_pkg::ST_EMIT_LD;
      end
      bod_pkg::ST_EMIT_LD: begin
        cmd.emit_ld = 1'b1;
        state_next  = bod_pkg::ST_EMIT_WAIT;
      end
      bod_pkg::ST_EMIT_WAIT: begin
        if (stat.out_valid && !out_stall) begin
          if (cnt == bod_pkg::LAST_INDEX) begin
            state_next = bod_pkg::ST_LOAD;
            cnt_next   = '0;
          end else begin
            state_next = bod_pkg::ST_EMIT_RD;
            cnt_next   = cnt + 7'd1;
          end
        end
      end
      default: begin
        state_next = bod_pkg::ST_LOAD;
        cnt_next   = '0;
      end
    endcase
  end

endmodule

// ----- design/bod_dp.sv -----
module bod_dp #(
  parameter int SAMPLE_BITS = 19
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic [18:0]       sample,
  input  bod_pkg::bod_cmd_t cmd,
  input  logic              out_stall,
  output bod_pkg::bod_stat_t stat,
  output logic              out_valid,
  output logic [19:0]       out_sample,
  output logic              block_changed,
  output logic              last
);

  localparam int SB   = SAMPLE_BITS;
  localparam int WW   = ((SB > 19) ? SB : 19) + 1;
  localparam int SUMW = SB + 6;
  localparam int LW   = ((SUMW > 23) ? SUMW : 23) + 1;
  localparam int CW   = ((SB > 17) ? SB : 17) + 1;
  localparam int AW   = WW + 4;

  logic [7:0]  low_clip_level;
  logic [15:0] high_clip_level;
  logic [8:0]  delta_floor;
  logic [15:0] dc_bucket;
  logic [12:0] min_overshoot;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_clip_level  <= 8'd15;
      high_clip_level <= 16'd4080;
      delta_floor     <= 9'd16;
      dc_bucket       <= 16'd16;
      min_overshoot   <= 13'd496;
    end else if (cfg_we) begin
      case (cfg_index)
        bod_pkg::CFG_LOW_CLIP:  low_clip_level  <= cfg_data[7:0];
        bod_pkg::CFG_HIGH_CLIP: high_clip_level <= cfg_data;
        bod_pkg::CFG_DELTA_FLR: delta_floor     <= cfg_data[8:0];
        bod_pkg::CFG_DC_BUCKET: dc_bucket       <= cfg_data;
        bod_pkg::CFG_MIN_OVS:   min_overshoot   <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // memories
  logic signed [SB-1:0] orig_mem [64];
  bod_pkg::bod_mark_t   mark_mem [64];
  logic signed [WW-1:0] work_a [64];
  logic signed [WW-1:0] work_b [64];

  logic signed [SB-1:0] orig_rd;
  bod_pkg::bod_mark_t   mark_rd;
  logic signed [WW-1:0] rd_a, rd_b, work_rd;

  logic [5:0] step6, step_m1, mark_raddr, work_raddr, win_waddr;
  logic       mark_wr, fill_wr, smooth_wr;
  logic       sel;

  logic signed [SB-1:0] s_in;
  assign s_in = $signed(SB'(sample));

  assign step6      = cmd.step[5:0];
  assign step_m1    = 6'(cmd.step - 7'd1);
  assign win_waddr  = 6'(cmd.step - bod_pkg::WIN_DELAY);
  assign mark_raddr = cmd.smooth ? 6'(cmd.step - bod_pkg::WIN_LEAD) : step6;
  assign work_raddr = (cmd.smooth && cmd.step[6]) ? 6'd63 : step6;
  assign mark_wr    = cmd.mark && (cmd.step != 7'd0);
  assign fill_wr    = cmd.fill && (cmd.step != 7'd0);
  assign smooth_wr  = cmd.smooth && (cmd.step >= bod_pkg::WIN_DELAY);
  assign work_rd    = sel ? rd_b : rd_a;

  // classification of one stored sample
  logic signed [CW-1:0] s_cmp, lo_cmp, hi_cmp;
  bod_pkg::bod_mark_t   mark_new;
  assign s_cmp  = CW'(orig_rd);
  assign lo_cmp = $signed(CW'(low_clip_level));
  assign hi_cmp = $signed(CW'(high_clip_level));
  always_comb begin
    if (s_cmp <= lo_cmp) mark_new = bod_pkg::MARK_DARK;
    else if (s_cmp >= hi_cmp) mark_new = bod_pkg::MARK_BRIGHT;
    else mark_new = bod_pkg::MARK_NONE;
  end

  logic signed [SUMW-1:0] block_sum;
  logic [6:0]             dark_count, bright_count;
  logic signed [WW-1:0]   bright_lvl, dark_lvl;
  logic                   changed;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      orig_mem[step6] <= s_in;
      block_sum <= ((cmd.step == 7'd0) ? '0 : block_sum) + SUMW'(s_in);
    end
    orig_rd <= orig_mem[step6];
    if (mark_wr) mark_mem[step_m1] <= mark_new;
    mark_rd <= mark_mem[mark_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.mark && cmd.step == 7'd0) begin
      dark_count   <= '0;
      bright_count <= '0;
    end else if (mark_wr) begin
      if (mark_new == bod_pkg::MARK_DARK) dark_count <= dark_count + 7'd1;
      if (mark_new == bod_pkg::MARK_BRIGHT) bright_count <= bright_count + 7'd1;
    end
  end

  // overshoot levels
  logic [15:0]          delta;
  logic [16:0]          ovs;
  logic signed [LW-1:0] hi64, lo64, sum_x, up_raw, down_raw, up, down, ovs_x;
  always_comb begin
    delta    = (dc_bucket < 16'(delta_floor)) ? 16'(delta_floor) : dc_bucket;
    ovs      = ({delta, 1'b0} < 17'(min_overshoot)) ? 17'(min_overshoot) : {delta, 1'b0};
    ovs_x    = $signed(LW'(ovs));
    hi64     = $signed(LW'({high_clip_level, 6'd0}));
    lo64     = $signed(LW'({low_clip_level, 6'd0}));
    sum_x    = LW'(block_sum);
    up_raw   = (hi64 - sum_x) >>> 6;
    down_raw = (sum_x - lo64) >>> 6;
    up       = (up_raw > ovs_x) ? ovs_x : up_raw;
    down     = (down_raw > ovs_x) ? ovs_x : down_raw;
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      bright_lvl <= WW'($signed(LW'(high_clip_level)) + up);
      dark_lvl   <= WW'($signed(LW'(low_clip_level)) - down);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      changed <= 1'b0;
      sel     <= 1'b0;
    end else begin
      if (cmd.decide) begin
        changed <= ((dark_count != 7'd0) && (dark_count != bod_pkg::BLOCK_LEN)) ||
                   ((bright_count != 7'd0) && (bright_count != bod_pkg::BLOCK_LEN));
        sel     <= 1'b0;
      end else if (cmd.swap) begin
        sel <= ~sel;
      end
    end
  end

  logic signed [WW-1:0] fill_val;
  always_comb begin
    fill_val = WW'(orig_rd);
    if (changed) begin
      case (mark_rd)
        bod_pkg::MARK_DARK:   fill_val = dark_lvl;
        bod_pkg::MARK_BRIGHT: fill_val = bright_lvl;
        default:              fill_val = WW'(orig_rd);
      endcase
    end
  end

  // smoothing window: win[0] is the sample below the center, win[16] above
  logic signed [WW-1:0] taps [16];
  logic signed [WW-1:0] win  [17];
  always_comb begin
    win[0] = work_rd;
    for (int j = 1; j < 17; j++) win[j] = taps[j-1];
  end

  always_ff @(posedge clk) begin
    if (cmd.smooth) begin
      for (int j = 0; j < 16; j++) taps[j] <= win[j];
    end
  end

  logic [2:0]           px, py;
  logic signed [WW-1:0] c, l, r, t, b, smooth_val;
  logic signed [AW-1:0] acc, v, lo_a, hi_a;
  always_comb begin
    px   = win_waddr[2:0];
    py   = win_waddr[5:3];
    c    = win[8];
    l    = (px != 3'd0) ? win[9]  : c;
    r    = (px != 3'd7) ? win[7]  : c;
    t    = (py != 3'd0) ? win[16] : c;
    b    = (py != 3'd7) ? win[0]  : c;
    acc  = (AW'(c) <<< 2) + AW'(l) + AW'(r) + AW'(t) + AW'(b);
    v    = ((acc | AW'(1)) + AW'(3)) >>> 3;
    lo_a = $signed(AW'(low_clip_level));
    hi_a = $signed(AW'(high_clip_level));
    if (AW'(c) <= lo_a && v > lo_a) v = lo_a;
    else if (AW'(c) >= hi_a && v < hi_a) v = hi_a;
    smooth_val = (mark_rd != bod_pkg::MARK_NONE) ? WW'(v) : c;
  end

  always_ff @(posedge clk) begin
    if (fill_wr) work_a[step_m1] <= fill_val;
    else if (smooth_wr && sel) work_a[win_waddr] <= smooth_val;
    if (smooth_wr && !sel) work_b[win_waddr] <= smooth_val;
    rd_a <= work_a[work_raddr];
    rd_b <= work_b[work_raddr];
  end

  // output register
  logic signed [WW-1:0] out_r;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_ld) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
    if (cmd.emit_ld) begin
      out_r <= work_rd;
      last  <= (cmd.step == bod_pkg::LAST_INDEX);
    end
  end

  assign out_sample     = out_r[19:0];
  assign block_changed  = changed;
  assign stat.changed   = changed;
  assign stat.out_valid = out_valid;

endmodule

// ----- design/block_overshoot_deringing.sv -----
// channel | direction | handshake           | payload
// input   | in        | in_valid / in_stall | sample
// output  | out       | out_valid/out_stall | out_sample, block_changed, last
// config  | in        | cfg_we              | cfg_index, cfg_data
//
// One block of 64 samples is loaded, marked, given one decision, filled and,
// only when the block changed, smoothed in SMOOTH_PASSES passes (the single
// read port of each work buffer streams the block once per pass); each sample
// is then read and emitted, and the next is read once the last has transferred.
// Reset (rst, synchronous) returns to loading and restores the register defaults.
// in_stall is high from the 64th transfer until the last result transfers;
// out_stall holds the current result and stops the block.
module block_overshoot_deringing #(
  parameter int SMOOTH_PASSES = 3,
  parameter int SAMPLE_BITS   = 19
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [18:0] sample,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [19:0] out_sample,
  output logic        block_changed,
  output logic        last
);

  bod_pkg::bod_cmd_t  cmd;
  bod_pkg::bod_stat_t stat;

  bod_ctrl #(.SMOOTH_PASSES(SMOOTH_PASSES)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .out_stall(out_stall),
    .stat     (stat),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  bod_dp #(.SAMPLE_BITS(SAMPLE_BITS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample       (sample),
    .cmd          (cmd),
    .out_stall    (out_stall),
    .stat         (stat),
    .out_valid    (out_valid),
    .out_sample   (out_sample),
    .block_changed(block_changed),
    .last         (last)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && !in_stall))
    else $error("input open while a result is pending");

  a_last_reopens: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && last) |=> (!in_stall && !out_valid))
    else $error("input not reopened after last result");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_stall))
    else $error("block not idle after reset");

endmodule
